>>> rtl/rrs_pkg.sv
// rrs_pkg: types and constants shared by the rotor/reflector substitution block
// depends on nothing; imported by rrs_search and rotor_reflector_substitution_top
`timescale 1ns / 1ps

package rrs_pkg;

    // word opcodes
    localparam logic OP_LOAD     = 1'b0;
    localparam logic OP_ENCIPHER = 1'b1;

    // wiring table codes
    localparam logic [1:0] TBL_RIGHT     = 2'd0;
    localparam logic [1:0] TBL_MIDDLE    = 2'd1;
    localparam logic [1:0] TBL_LEFT      = 2'd2;
    localparam logic [1:0] TBL_REFLECTOR = 2'd3;

    // character constants
    localparam logic [7:0] CHAR_A8       = 8'h41;
    localparam logic [6:0] CHAR_A7       = 7'h41;
    localparam int         LETTER_COUNT  = 26;
    localparam logic [6:0] LETTER_COUNT7 = 7'(LETTER_COUNT);

    // mask memory address: table code and 8-bit character
    localparam int MASK_AW = 10;

    typedef enum logic [1:0] {
        MASK_NOP,
        MASK_READ,
        MASK_CLEAR_BIT,
        MASK_SET_BIT
    } mask_op_t;

    typedef struct packed {
        mask_op_t   op;
        logic       zero;   // clearing pass: write the whole entry to zero
        logic [1:0] tbl;
        logic [7:0] ch;
    } mask_req_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LD_OLD,
        S_LD_WR,
        S_LD_CLR,
        S_LD_RDN,
        S_LD_SET,
        S_E_RIGHT,
        S_E_MIDDLE,
        S_E_LEFT,
        S_E_REFL,
        S_E_SRCH_L,
        S_E_SRCH_M,
        S_E_SRCH_R,
        S_E_OUT
    } state_t;

    // capital letter of an alphabet index, 'A' past the end of the alphabet
    function automatic logic [6:0] letter_of(input logic [6:0] p);
        logic [6:0] res;
        res = CHAR_A7;
        if (p < LETTER_COUNT7)
        begin
            res = CHAR_A7 + p;
        end
        return res;
    endfunction

endpackage

>>> rtl/rrs_search.sv
// rrs_search: per-character index masks of the three rotor tables, with
// read-modify-write update and lowest-index priority encode
// depends on rrs_pkg
`timescale 1ns / 1ps

module rrs_search
    import rrs_pkg::*;
#(
    parameter int ALPHABET_SIZE = 26
)
(
    input  logic                             clk,
    input  mask_req_t                        req,
    input  logic [$clog2(ALPHABET_SIZE)-1:0] bit_index,
    output logic [$clog2(ALPHABET_SIZE)-1:0] hit_index
);

    localparam int IW = $clog2(ALPHABET_SIZE);

    // bit i of entry {tbl, ch} is set when that table holds ch at index i
    logic [ALPHABET_SIZE-1:0] mask_mem [2**MASK_AW];
    logic [ALPHABET_SIZE-1:0] rd_reg;
    logic [ALPHABET_SIZE-1:0] bit_onehot;
    logic [MASK_AW-1:0]       addr;

    assign addr       = {req.tbl, req.ch};
    assign bit_onehot = {{(ALPHABET_SIZE-1){1'b0}}, 1'b1} << bit_index;

    always_ff @(posedge clk)
    begin
        if (req.zero)
        begin
            mask_mem[addr] <= '0;
        end
        else
        begin
            case (req.op)
                MASK_READ:      rd_reg <= mask_mem[addr];
                MASK_CLEAR_BIT: mask_mem[addr] <= rd_reg & ~bit_onehot;
                MASK_SET_BIT:   mask_mem[addr] <= rd_reg | bit_onehot;
                default:        ;
            endcase
        end
    end

    // lowest set bit wins, no bit gives index 0
    always_comb
    begin
        hit_index = '0;
        for (int i = ALPHABET_SIZE - 1; i >= 0; i--)
        begin
            if (rd_reg[i])
            begin
                hit_index = IW'(i);
            end
        end
    end

endmodule

>>> rtl/rotor_reflector_substitution_top.sv
// rotor_reflector_substitution_top: four wiring tables, load and encipher sequencer
// depends on rrs_pkg and rrs_search
// encipher word: wiring reads right, middle, left, reflector, then mask searches
//   left, middle, right, one wiring or mask memory access per cycle; the result
//   waits for a free output register, and only then is the next word taken
// load word: old entry read, then write; a rotor adds its index mask update
// reset: a clearing pass zeroes the 1024-entry mask memory, one entry per
//   cycle, so input stays stalled until the pass completes
`timescale 1ns / 1ps

module rotor_reflector_substitution_top
    import rrs_pkg::*;
#(
    parameter int ALPHABET_SIZE = 26
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       op,
    input  logic [1:0] table_select,
    input  logic [4:0] entry_index,
    input  logic [7:0] entry_char,
    input  logic [7:0] plain_char,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [6:0] cipher_char
);

    localparam int         IW          = $clog2(ALPHABET_SIZE);
    localparam int         WA          = IW + 2;
    localparam logic [6:0] SIZE7       = 7'(ALPHABET_SIZE);
    localparam int         ALPHA_LIMIT = (ALPHABET_SIZE < LETTER_COUNT) ?
                                         ALPHABET_SIZE : LETTER_COUNT;
    localparam logic [7:0] ALPHA_LIM8  = 8'(ALPHA_LIMIT);

    // alphabet position of a character, 0 for anything not a usable capital
    function automatic logic [IW-1:0] pos_of(input logic [7:0] ch);
        logic [7:0]    d;
        logic [IW-1:0] res;
        d   = ch - CHAR_A8;
        res = '0;
        if (ch >= CHAR_A8 && d < ALPHA_LIM8)
        begin
            res = IW'(d);
        end
        return res;
    endfunction

    // control and captured word
    state_t           state_reg, state_next;
    logic [1:0]       sel_reg, sel_next;
    logic [IW-1:0]    idx_reg, idx_next;
    logic [7:0]       char_reg, char_next;
    logic [MASK_AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic [6:0]       cipher_reg, cipher_next;

    // wiring memory: entry {table, index}
    logic [7:0]       wiring_mem [2**WA];
    logic [7:0]       wiring_rd_reg;
    logic             wiring_rd_en;
    logic [WA-1:0]    wiring_rd_addr;
    logic             wiring_wr_en;

    // index mask search unit
    mask_req_t        mask_req;
    logic [IW-1:0]    hit_index;
    logic [6:0]       hit_letter;

    logic             in_accept;
    logic             out_free;

    assign in_stall    = (state_reg != S_IDLE);
    assign in_accept   = in_valid && !in_stall;
    assign out_valid   = out_valid_reg;
    assign cipher_char = cipher_reg;
    assign out_free    = !out_valid_reg || !out_stall;
    assign hit_letter  = letter_of(7'(hit_index));

    always_ff @(posedge clk)
    begin
        if (wiring_wr_en)
        begin
            wiring_mem[{sel_reg, idx_reg}] <= char_reg;
        end
        if (wiring_rd_en)
        begin
            wiring_rd_reg <= wiring_mem[wiring_rd_addr];
        end
    end

    rrs_search #(
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_search (
        .clk       (clk),
        .req       (mask_req),
        .bit_index (idx_reg),
        .hit_index (hit_index)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sel_reg    <= sel_next;
        idx_reg    <= idx_next;
        char_reg   <= char_next;
        cipher_reg <= cipher_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        sel_next       = sel_reg;
        idx_next       = idx_reg;
        char_next      = char_reg;
        clr_cnt_next   = clr_cnt_reg;
        cipher_next    = cipher_reg;
        out_valid_next = out_valid_reg && out_stall;
        wiring_rd_en   = 1'b0;
        wiring_rd_addr = {sel_reg, idx_reg};
        wiring_wr_en   = 1'b0;
        mask_req.op    = MASK_NOP;
        mask_req.zero  = 1'b0;
        mask_req.tbl   = sel_reg;
        mask_req.ch    = char_reg;

        case (state_reg)
            // zero every mask entry so unused characters never match
            S_CLEAR:
            begin
                mask_req.zero = 1'b1;
                mask_req.tbl  = clr_cnt_reg[MASK_AW-1 -: 2];
                mask_req.ch   = clr_cnt_reg[7:0];
                clr_cnt_next  = clr_cnt_reg + 1'b1;
                if (&clr_cnt_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_accept)
                begin
                    sel_next = table_select;
                    idx_next = IW'(entry_index);
                    if (op == OP_ENCIPHER)
                    begin
                        char_next  = plain_char;
                        state_next = S_E_RIGHT;
                    end
                    else
                    begin
                        char_next = entry_char;
                        // out-of-range index: word dropped
                        if ({2'b00, entry_index} < SIZE7)
                        begin
                            state_next = S_LD_OLD;
                        end
                    end
                end
            end
            // load: fetch the character being replaced
            S_LD_OLD:
            begin
                wiring_rd_en = 1'b1;
                state_next   = S_LD_WR;
            end
            S_LD_WR:
            begin
                wiring_wr_en = 1'b1;
                if (sel_reg == TBL_REFLECTOR)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    mask_req.op = MASK_READ;
                    mask_req.ch = wiring_rd_reg;
                    state_next  = S_LD_CLR;
                end
            end
            // old character no longer sits at this index
            S_LD_CLR:
            begin
                mask_req.op = MASK_CLEAR_BIT;
                mask_req.ch = wiring_rd_reg;
                state_next  = S_LD_RDN;
            end
            S_LD_RDN:
            begin
                mask_req.op = MASK_READ;
                state_next  = S_LD_SET;
            end
            S_LD_SET:
            begin
                mask_req.op = MASK_SET_BIT;
                state_next  = S_IDLE;
            end
            // forward path: right, middle, left, reflector
            S_E_RIGHT:
            begin
                wiring_rd_en   = 1'b1;
                wiring_rd_addr = {TBL_RIGHT, pos_of(char_reg)};
                state_next     = S_E_MIDDLE;
            end
            S_E_MIDDLE:
            begin
                wiring_rd_en   = 1'b1;
                wiring_rd_addr = {TBL_MIDDLE, pos_of(wiring_rd_reg)};
                state_next     = S_E_LEFT;
            end
            S_E_LEFT:
            begin
                wiring_rd_en   = 1'b1;
                wiring_rd_addr = {TBL_LEFT, pos_of(wiring_rd_reg)};
                state_next     = S_E_REFL;
            end
            S_E_REFL:
            begin
                wiring_rd_en   = 1'b1;
                wiring_rd_addr = {TBL_REFLECTOR, pos_of(wiring_rd_reg)};
                state_next     = S_E_SRCH_L;
            end
            // backward path: inverse search left, middle, right
            S_E_SRCH_L:
            begin
                mask_req.op  = MASK_READ;
                mask_req.tbl = TBL_LEFT;
                mask_req.ch  = wiring_rd_reg;
                state_next   = S_E_SRCH_M;
            end
            S_E_SRCH_M:
            begin
                mask_req.op  = MASK_READ;
                mask_req.tbl = TBL_MIDDLE;
                mask_req.ch  = {1'b0, hit_letter};
                state_next   = S_E_SRCH_R;
            end
            S_E_SRCH_R:
            begin
                mask_req.op  = MASK_READ;
                mask_req.tbl = TBL_RIGHT;
                mask_req.ch  = {1'b0, hit_letter};
                state_next   = S_E_OUT;
            end
            // hold the mask read until the output register frees up
            S_E_OUT:
            begin
                if (out_free)
                begin
                    cipher_next    = hit_letter;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
